FILE: design/motor_command_frame_encoder_macros.svh
// assertion helpers for the checker file
`ifndef MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH

// property checked every clock outside reset
`define MCFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mcfe assertion failed");

// condition in one cycle implies a condition in the next
`define MCFE_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("mcfe assertion failed");

`endif

FILE: design/mcfe_pkg.sv
package mcfe_pkg;

  localparam int FRAME_LEN   = 34;
  localparam int CRC_WORDS   = 7;
  localparam int CRC_BYTES   = CRC_WORDS * 4;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int CCNT_W      = $clog2(CRC_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // 2^32 / (8 * 3.1415926), rounded, unsigned q0.32
  localparam int          GAIN_W   = 28;
  localparam logic [GAIN_W-1:0] POS_GAIN = 28'd170891322;
  localparam int          PROD_W   = 32 + GAIN_W;

  localparam logic [7:0] HDR_SYNC0 = 8'hFE;
  localparam logic [7:0] HDR_SYNC1 = 8'hEE;
  localparam logic [7:0] HDR_FLAG  = 8'hFF;

  localparam logic [IDX_W-1:0] OFS_SYNC0  = IDX_W'(0);
  localparam logic [IDX_W-1:0] OFS_SYNC1  = IDX_W'(1);
  localparam logic [IDX_W-1:0] OFS_ID     = IDX_W'(2);
  localparam logic [IDX_W-1:0] OFS_MODE   = IDX_W'(4);
  localparam logic [IDX_W-1:0] OFS_FLAG   = IDX_W'(5);
  localparam logic [IDX_W-1:0] OFS_TORQUE = IDX_W'(12);
  localparam logic [IDX_W-1:0] OFS_SPEED  = IDX_W'(14);
  localparam logic [IDX_W-1:0] OFS_POS    = IDX_W'(16);
  localparam logic [IDX_W-1:0] OFS_STIFF  = IDX_W'(20);
  localparam logic [IDX_W-1:0] OFS_DAMP   = IDX_W'(22);
  localparam logic [IDX_W-1:0] OFS_CRC    = IDX_W'(30);
  localparam logic [IDX_W-1:0] OFS_LAST   = IDX_W'(FRAME_LEN - 1);

  localparam int unsigned TORQUE_SHIFT = 8;
  localparam int unsigned SPEED_SHIFT  = 9;
  localparam int unsigned STIFF_SHIFT  = 5;
  localparam int unsigned DAMP_SHIFT   = 7;

  localparam int PADDR_W = 3;
  localparam int REGIDX_W = PADDR_W - 2;
  localparam logic [REGIDX_W-1:0] REG_TARGET_ID = REGIDX_W'(0);

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] torque_cmd;
    logic signed [31:0] speed_cmd;
    logic signed [31:0] position_cmd;
    logic signed [31:0] stiffness_cmd;
    logic signed [31:0] damping_cmd;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]  target_id;
    logic [1:0]  mode;
    logic [15:0] torque;
    logic [15:0] speed;
    logic [31:0] position;
    logic [15:0] stiffness;
    logic [15:0] damping;
  } frame_body_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } queue_status_t;

  // q16.16 to int16: shift, round half away from zero, saturate
  function automatic logic [15:0] q16_to_i16(input logic [31:0] x, input int unsigned shift);
    logic        neg;
    logic [31:0] mag;
    logic [32:0] sum;
    logic [32:0] q;
    logic [15:0] r;
    neg = x[31];
    mag = neg ? (~x + 32'd1) : x;
    sum = {1'b0, mag} + (33'd1 << (shift - 1));
    q   = sum >> shift;
    if (neg) begin
      if (q > 33'd32768) r = 16'h8000;
      else r = ~q[15:0] + 16'd1;
    end else begin
      if (q > 33'd32767) r = 16'h7FFF;
      else r = q[15:0];
    end
    return r;
  endfunction

  // msb-first crc update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    c = crc;
    for (int b = 7; b >= 0; b--) begin
      if (c[31] ^ d[b]) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

FILE: design/motor_command_frame_encoder.sv
// Motor command frame encoder. Each accepted command request is converted to
// wire units (torque q8, speed q7, position in 16384/2pi counts per radian,
// stiffness q11, damping q9, all rounded half away from zero and saturated)
// and sent out as a 34-byte little-endian frame, one byte per output request,
// with last_byte set on byte 33. The frame ends in a CRC-32/MPEG-2 over its
// first 28 bytes. The output channel moves one byte per cycle while out_ready_i
// is high and the CRC is not holding it back; a new command is taken while
// the previous frame is still streaming, and two more can wait in the queue.
// A command passes two conversion stages, the second holding the position
// multiply, then the queue, the frame register and the output register
// before its first byte appears. The CRC is built one byte per cycle from
// the moment the frame is loaded and is complete before byte 30 is due at
// full rate.
// target_id sits at APB address 0 and is read back there; pready is always
// high.
module motor_command_frame_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mcfe_pkg::cmd_item_t                 in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mcfe_pkg::frame_item_t               out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcfe_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import mcfe_pkg::*;

  logic [7:0]          target_id_q;
  logic [REGIDX_W-1:0] reg_idx;
  logic                front_valid, queue_pop;
  frame_body_t         front_body, queue_body;
  queue_status_t       queue_status;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_TARGET_ID) ? {24'd0, target_id_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q <= 8'd0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_TARGET_ID)) begin
      target_id_q <= pwdata[7:0];
    end
  end

  mcfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .target_id_i  (target_id_q),
    .body_valid_o (front_valid),
    .body_ready_i (queue_status.not_full),
    .body_o       (front_body)
  );

  mcfe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_valid),
    .data_i   (front_body),
    .pop_i    (queue_pop),
    .data_o   (queue_body),
    .status_o (queue_status)
  );

  mcfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .body_valid_i (queue_status.not_empty),
    .body_pop_o   (queue_pop),
    .body_i       (queue_body),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

FILE: design/mcfe_queue.sv
module mcfe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mcfe_pkg::frame_body_t data_i,
  input  logic                  pop_i,
  output mcfe_pkg::frame_body_t data_o,
  output mcfe_pkg::queue_status_t status_o
);
  import mcfe_pkg::*;

  frame_body_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.not_full  = count_q != QCNT_W'(QUEUE_DEPTH);
  assign status_o.not_empty = count_q != '0;
  assign do_push = push_i && status_o.not_full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: design/mcfe_front.sv
module mcfe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mcfe_pkg::cmd_item_t   in_i,
  input  logic [7:0]            target_id_i,
  output logic                  body_valid_o,
  input  logic                  body_ready_i,
  output mcfe_pkg::frame_body_t body_o
);
  import mcfe_pkg::*;

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  frame_body_t       s1_q, s2_q;
  logic              pneg1_q, pneg2_q;
  logic [PROD_W-1:0] prod2_q;
  logic [PROD_W-1:0] rounded;
  logic [31:0]       pos_mag;
  logic [31:0]       pos_abs;
  frame_body_t       s1_d;

  assign rdy2       = !v2_q || body_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: int16 conversions and position magnitude
  always_comb begin
    pos_mag        = in_i.position_cmd[31] ? (~in_i.position_cmd + 32'd1) : in_i.position_cmd;
    s1_d.target_id = target_id_i;
    s1_d.mode      = in_i.mode;
    s1_d.torque    = q16_to_i16(in_i.torque_cmd, TORQUE_SHIFT);
    s1_d.speed     = q16_to_i16(in_i.speed_cmd, SPEED_SHIFT);
    s1_d.position  = pos_mag;
    s1_d.stiffness = q16_to_i16(in_i.stiffness_cmd, STIFF_SHIFT);
    s1_d.damping   = q16_to_i16(in_i.damping_cmd, DAMP_SHIFT);
  end

  // stage 2 output: round the scaled position and restore its sign
  always_comb begin
    rounded = prod2_q + (PROD_W'(1) << 31);
    pos_abs = 32'(rounded[PROD_W-1:32]);
    body_o  = s2_q;
    body_o.position = pneg2_q ? (~pos_abs + 32'd1) : pos_abs;
  end

  assign body_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      s1_q    <= s1_d;
      pneg1_q <= in_i.position_cmd[31];
    end
    if (v1_q && rdy2) begin
      s2_q    <= s1_q;
      pneg2_q <= pneg1_q;
      prod2_q <= PROD_W'(s1_q.position) * PROD_W'(POS_GAIN);
    end
  end

endmodule

FILE: design/mcfe_back.sv
module mcfe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  body_valid_i,
  output logic                  body_pop_o,
  input  mcfe_pkg::frame_body_t body_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mcfe_pkg::frame_item_t out_o
);
  import mcfe_pkg::*;

  function automatic logic [7:0] body_byte(input frame_body_t b, input logic [IDX_W-1:0] idx,
                                           input logic [31:0] crc);
    logic [7:0] r;
    case (idx)
      OFS_SYNC0:             r = HDR_SYNC0;
      OFS_SYNC1:             r = HDR_SYNC1;
      OFS_ID:                r = b.target_id;
      OFS_MODE:              r = {6'd0, b.mode};
      OFS_FLAG:              r = HDR_FLAG;
      OFS_TORQUE:            r = b.torque[7:0];
      OFS_TORQUE + IDX_W'(1): r = b.torque[15:8];
      OFS_SPEED:             r = b.speed[7:0];
      OFS_SPEED + IDX_W'(1): r = b.speed[15:8];
      OFS_POS:               r = b.position[7:0];
      OFS_POS + IDX_W'(1):   r = b.position[15:8];
      OFS_POS + IDX_W'(2):   r = b.position[23:16];
      OFS_POS + IDX_W'(3):   r = b.position[31:24];
      OFS_STIFF:             r = b.stiffness[7:0];
      OFS_STIFF + IDX_W'(1): r = b.stiffness[15:8];
      OFS_DAMP:              r = b.damping[7:0];
      OFS_DAMP + IDX_W'(1):  r = b.damping[15:8];
      OFS_CRC:               r = crc[7:0];
      OFS_CRC + IDX_W'(1):   r = crc[15:8];
      OFS_CRC + IDX_W'(2):   r = crc[23:16];
      OFS_CRC + IDX_W'(3):   r = crc[31:24];
      default:               r = 8'd0;
    endcase
    return r;
  endfunction

  logic              busy_q;
  frame_body_t       body_q;
  logic [IDX_W-1:0]  idx_q;
  logic [31:0]       crc_q;
  logic [CCNT_W-1:0] ccnt_q;
  logic              out_valid_q;
  frame_item_t       out_q;
  logic              out_free, crc_done, fire, is_last, load;
  logic [IDX_W-1:0]  crc_idx;
  logic [7:0]        crc_in;

  assign out_free = !out_valid_q || out_ready_i;
  assign crc_done = ccnt_q == CCNT_W'(CRC_BYTES);
  // crc bytes may only leave once the accumulation has finished
  assign fire     = busy_q && out_free && (crc_done || (idx_q < OFS_CRC));
  assign is_last  = idx_q == OFS_LAST;
  assign load     = body_valid_i && (!busy_q || (fire && is_last));
  assign body_pop_o = load;

  // crc runs over words msb first, little-endian: byte order 3,2,1,0 per word
  assign crc_idx = IDX_W'(ccnt_q) ^ IDX_W'(3);
  assign crc_in  = body_byte(body_q, crc_idx, crc_q);

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      ccnt_q      <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (load) busy_q <= 1'b1;
      else if (fire && is_last) busy_q <= 1'b0;

      if (load) idx_q <= '0;
      else if (fire) idx_q <= idx_q + 1'b1;

      if (load) begin
        ccnt_q <= '0;
        crc_q  <= CRC_INIT;
      end else if (busy_q && !crc_done) begin
        ccnt_q <= ccnt_q + 1'b1;
        crc_q  <= crc_byte(crc_q, crc_in);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) body_q <= body_i;
    if (fire) begin
      out_q.frame_byte <= body_byte(body_q, idx_q, crc_q);
      out_q.last_byte  <= is_last;
    end
  end

endmodule

FILE: design/mcfe_checker.sv
`include "motor_command_frame_encoder_macros.svh"

module mcfe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input mcfe_pkg::frame_item_t        out_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [mcfe_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import mcfe_pkg::*;

  logic [IDX_W-1:0] cnt_q;
  logic [7:0]       wdata_q;
  logic             out_fire, out_wait, frame_first;
  logic             id_sel, id_write, id_ok;

  assign out_fire    = out_valid_o && out_ready_i;
  assign out_wait    = out_valid_o && !out_ready_i;
  assign frame_first = out_fire && (cnt_q == OFS_SYNC0);
  assign id_sel      = paddr[PADDR_W-1:2] == REG_TARGET_ID;
  assign id_write    = psel && penable && pwrite && pready && id_sel;
  assign id_ok       = !id_sel || (prdata[7:0] == wdata_q);

  // position of the next output byte within its frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_fire) begin
      cnt_q <= out_o.last_byte ? '0 : cnt_q + 1'b1;
    end
  end

  // write data of the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdata_q <= 8'd0;
    end else begin
      wdata_q <= pwdata[7:0];
    end
  end

  `MCFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_o))
  `MCFE_ASSERT(a_frame_start, clk_i, rst_ni, frame_first |-> (out_o.frame_byte == HDR_SYNC0))
  `MCFE_ASSERT(a_frame_len, clk_i, rst_ni, out_fire |-> (out_o.last_byte == (cnt_q == OFS_LAST)))
  `MCFE_ASSERT_NEXT(a_id_readback, clk_i, rst_ni, id_write, id_ok)

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (.*);

FILE: tb/sv/tb_top.sv
module tb_top;
  import mcfe_pkg::*;

  localparam int          STALL_LIMIT = 5000;
  localparam int          TAIL_CYCLES = 20;
  localparam logic [31:0] CRC32_POLY  = 32'h04C1_1DB7;
  localparam logic [31:0] CRC32_SEED  = 32'hFFFF_FFFF;
  localparam logic [63:0] RAD_GAIN    = 64'd170891322;
  localparam logic [PADDR_W-1:0] ADDR_TARGET_ID = {REG_TARGET_ID, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = {~REG_TARGET_ID, 2'b00};

  typedef logic [FRAME_LEN-1:0][7:0] frame_vec_t;

  // one command request plus, for hand-checked rows, its wire values
  typedef struct {
    cmd_item_t   cmd;
    bit          typed;
    logic [15:0] trq_wire;
    logic [15:0] spd_wire;
    logic [31:0] pos_counts;
    logic [15:0] stiff_q11;
    logic [15:0] damp_q9;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  cmd_item_t   in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  frame_item_t out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cmd_row_t    cur_row;
  frame_item_t pending_bytes[$];
  logic [7:0]  target_shadow = 8'h00;
  int          tx_idle_pct = 34;
  int          rx_idle_pct = 87;
  int          errors = 0;
  int          cmds_accepted = 0;
  int          bytes_checked = 0;
  int          id_writes = 0;

  motor_command_frame_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // q16.16 to int16 wire value: shift with round half away, then clamp
  function automatic logic [15:0] round_sat16(input logic [31:0] v, input int unsigned sh);
    logic [32:0] mag;
    logic [32:0] q;
    mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    q   = (mag + (33'd1 << (sh - 1))) >> sh;
    if (v[31]) begin
      if (q > 33'd32768) q = 33'd32768;
      return 16'(33'h1_0000 - q);
    end
    if (q > 33'd32767) q = 33'd32767;
    return q[15:0];
  endfunction

  // radians q16.16 to 16384 counts per turn
  function automatic logic [31:0] rad_to_counts(input logic [31:0] v);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    prod = mag * RAD_GAIN + 64'h8000_0000;
    return v[31] ? (32'd0 - prod[63:32]) : prod[63:32];
  endfunction

  // crc-32/mpeg-2 over the first seven little-endian words, msb first
  function automatic logic [31:0] frame_checksum(input frame_vec_t f);
    logic [31:0] c;
    logic [31:0] w;
    logic        fbk;
    c = CRC32_SEED;
    for (int i = 0; i < 7; i++) begin
      w = {f[4*i+3], f[4*i+2], f[4*i+1], f[4*i]};
      for (int b = 31; b >= 0; b--) begin
        fbk = c[31] ^ w[b];
        c   = c << 1;
        if (fbk) c = c ^ CRC32_POLY;
      end
    end
    return c;
  endfunction

  function automatic frame_vec_t assemble_frame(
    input logic [7:0] id, input logic [1:0] mode, input logic [15:0] trq,
    input logic [15:0] spd, input logic [31:0] pos, input logic [15:0] kp,
    input logic [15:0] kd);
    frame_vec_t   f;
    logic [31:0]  crc;
    f     = '0;
    f[0]  = 8'hFE;
    f[1]  = 8'hEE;
    f[2]  = id;
    f[4]  = {6'd0, mode};
    f[5]  = 8'hFF;
    f[12] = trq[7:0];
    f[13] = trq[15:8];
    f[14] = spd[7:0];
    f[15] = spd[15:8];
    for (int i = 0; i < 4; i++) f[16+i] = pos[8*i +: 8];
    f[20] = kp[7:0];
    f[21] = kp[15:8];
    f[22] = kd[7:0];
    f[23] = kd[15:8];
    crc   = frame_checksum(f);
    for (int i = 0; i < 4; i++) f[30+i] = crc[8*i +: 8];
    return f;
  endfunction

  function automatic cmd_row_t mk_row(
    input bit typed, input logic [1:0] m, input logic [31:0] t, input logic [31:0] s,
    input logic [31:0] p, input logic [31:0] k, input logic [31:0] d,
    input logic [15:0] et, input logic [15:0] es, input logic [31:0] ep,
    input logic [15:0] ek, input logic [15:0] ed);
    cmd_row_t r;
    r.cmd.mode          = m;
    r.cmd.torque_cmd    = t;
    r.cmd.speed_cmd     = s;
    r.cmd.position_cmd  = p;
    r.cmd.stiffness_cmd = k;
    r.cmd.damping_cmd   = d;
    r.typed             = typed;
    r.trq_wire          = et;
    r.spd_wire          = es;
    r.pos_counts        = ep;
    r.stiff_q11         = ek;
    r.damp_q9           = ed;
    return r;
  endfunction

  // mix of full-range, in-range, clamp-edge, rounding-edge and extreme values
  function automatic logic [31:0] rand_q16(input int unsigned sh);
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'd32768 << sh);
      2: v = (32'd32767 << sh) + $urandom_range(0, 32'd2 << sh) - (32'd1 << sh);
      3: v = ($urandom_range(0, 4000) << sh) + (32'd1 << (sh - 1))
             + $urandom_range(0, 2) - 32'd1;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  function automatic cmd_row_t random_row();
    return mk_row(1'b0, 2'($urandom_range(0, 3)), rand_q16(8), rand_q16(9),
                  rand_q16(11), rand_q16(5), rand_q16(7), '0, '0, '0, '0, '0);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // predict the frame of each accepted request and check streamed bytes
  always @(posedge clk_i) begin : frame_monitor
    frame_vec_t   f;
    frame_item_t  exp_item;
    if (rst_ni && in_valid_i && in_ready_o) begin
      cmds_accepted++;
      if (cur_row.typed)
        f = assemble_frame(target_shadow, cur_row.cmd.mode, cur_row.trq_wire,
                           cur_row.spd_wire, cur_row.pos_counts, cur_row.stiff_q11,
                           cur_row.damp_q9);
      else
        f = assemble_frame(target_shadow, cur_row.cmd.mode,
                           round_sat16(cur_row.cmd.torque_cmd, 8),
                           round_sat16(cur_row.cmd.speed_cmd, 9),
                           rad_to_counts(cur_row.cmd.position_cmd),
                           round_sat16(cur_row.cmd.stiffness_cmd, 5),
                           round_sat16(cur_row.cmd.damping_cmd, 7));
      for (int k = 0; k < FRAME_LEN; k++) begin
        exp_item.frame_byte = f[k];
        exp_item.last_byte  = (k == FRAME_LEN - 1);
        pending_bytes.push_back(exp_item);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (last_byte %0b)", out_o.frame_byte,
               out_o.last_byte);
        errors++;
      end else begin
        exp_item = pending_bytes.pop_front();
        bytes_checked++;
        if (out_o.frame_byte !== exp_item.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", exp_item.frame_byte,
                 out_o.frame_byte);
          errors++;
        end
        if (out_o.last_byte !== exp_item.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", exp_item.last_byte,
                 out_o.last_byte);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_row(input cmd_row_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= r.cmd;
    cur_row    <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off requests until every predicted byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ADDR_TARGET_ID) begin
      target_shadow = d[7:0];
      id_writes++;
    end
    @(posedge clk_i);
  endtask

  task automatic check_target_id();
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TARGET_ID;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {24'd0, target_shadow}) begin
      $error("target_id readback: expected %08h, actual %08h", {24'd0, target_shadow}, rd);
      errors++;
    end
    @(posedge clk_i);
  endtask

  initial begin : main
    cmd_row_t directed[$];
    directed.push_back(mk_row(1, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                              16'h0000, 16'h0000, 32'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_row(1, 2'd1, 32'h10000, 32'h10000, 32'h0, 32'h10000, 32'h10000,
                              16'h0100, 16'h0080, 32'h0, 16'h0800, 16'h0200));
    directed.push_back(mk_row(1, 2'd2, 32'hFFFF0000, 32'hFFFF0000, 32'h0, 32'hFFFF0000,
                              32'hFFFF0000, 16'hFF00, 16'hFF80, 32'h0, 16'hF800, 16'hFE00));
    // unused mode code goes out unchanged
    directed.push_back(mk_row(1, 2'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 32'h0, 16'h7FFF, 16'h7FFF));
    directed.push_back(mk_row(1, 2'd0, 32'h80000000, 32'h80000000, 32'h0, 32'h80000000,
                              32'h80000000, 16'h8000, 16'h8000, 32'h0, 16'h8000, 16'h8000));
    // exact halves round away from zero
    directed.push_back(mk_row(1, 2'd1, 32'h80, 32'h100, 32'h0, 32'h10, 32'h40,
                              16'h0001, 16'h0001, 32'h0, 16'h0001, 16'h0001));
    directed.push_back(mk_row(1, 2'd2, 32'hFFFFFF80, 32'hFFFFFF00, 32'h0, 32'hFFFFFFF0,
                              32'hFFFFFFC0, 16'hFFFF, 16'hFFFF, 32'h0, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_row(1, 2'd1, 32'h7F, 32'hFF, 32'h0, 32'hF, 32'h3F,
                              16'h0000, 16'h0000, 32'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_row(1, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000, 16'h0000, 32'h0,
                              16'h0000, 16'h0000));
    // largest positive code, then a half step above it that must clamp
    directed.push_back(mk_row(1, 2'd0, 32'h7FFF00, 32'hFFFE00, 32'h0, 32'hFFFE0, 32'h3FFF80,
                              16'h7FFF, 16'h7FFF, 32'h0, 16'h7FFF, 16'h7FFF));
    directed.push_back(mk_row(1, 2'd1, 32'h7FFF80, 32'hFFFF00, 32'h0, 32'hFFFF0, 32'h3FFFC0,
                              16'h7FFF, 16'h7FFF, 32'h0, 16'h7FFF, 16'h7FFF));
    directed.push_back(mk_row(1, 2'd2, 32'hFF800000, 32'hFF000000, 32'h0, 32'hFFF00000,
                              32'hFFC00000, 16'h8000, 16'h8000, 32'h0, 16'h8000, 16'h8000));
    directed.push_back(mk_row(0, 2'd0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0,
                              '0, '0, '0, '0, '0));
    directed.push_back(mk_row(0, 2'd1, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0,
                              '0, '0, '0, '0, '0));
    directed.push_back(mk_row(0, 2'd2, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0,
                              '0, '0, '0, '0, '0));
    directed.push_back(mk_row(0, 2'd3, 32'h0, 32'h0, 32'hFFFF0000, 32'h0, 32'h0,
                              '0, '0, '0, '0, '0));
    directed.push_back(mk_row(0, 2'd2, 32'hAAAAAAAA, 32'h55555555, 32'h12345678,
                              32'hDEADBEEF, 32'h0F0F0F0F, '0, '0, '0, '0, '0));
    directed.push_back(mk_row(0, 2'd1, 32'h55555555, 32'hAAAAAAAA, 32'hEDCBA988,
                              32'h21524111, 32'hF0F0F0F0, '0, '0, '0, '0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_target_id();

    // directed frames with target_id at its reset value
    foreach (directed[i]) send_row(directed[i]);
    wait_drained();

    // a write to the unmapped slot must leave target_id alone
    apb_write(ADDR_UNMAPPED, $urandom);
    check_target_id();
    apb_write(ADDR_TARGET_ID, 32'h0000_00FF);
    check_target_id();
    for (int i = 0; i < 30; i++) send_row(random_row());
    wait_drained();

    apb_write(ADDR_TARGET_ID, $urandom);
    check_target_id();
    tx_idle_pct = 87;
    rx_idle_pct = 34;
    for (int i = 0; i < 30; i++) begin
      if (i == 15) wait_drained();
      send_row(random_row());
    end
    wait_drained();

    apb_write(ADDR_TARGET_ID, 32'h0000_0000);
    check_target_id();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 32; i++) send_row(random_row());
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d command frames, %0d bytes, under three pacing mixes",
             cmds_accepted, bytes_checked);
    $display("target_id written %0d times including 0x00 and 0xff, with readback",
             id_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
